// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Expect signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define KLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/kli_pkg.sv =====
// Package for the keyframe linear interpolator: transaction types and codes.
// No dependencies.
package kli_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register indexes (paddr[ADDR_W-1:2])
	localparam logic REG_KEY_COUNT = 1'b0;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Result region codes
	localparam logic [1:0] REGION_FIRST  = 2'd0;
	localparam logic [1:0] REGION_INTERP = 2'd1;
	localparam logic [1:0] REGION_LAST   = 2'd2;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         key_slot;
		logic [31:0]        key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0]        query_time;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [1:0]         region;
	} rsp_t;

endpackage

// ===== design/kli_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on kli_pkg.
interface kli_req_if;
	import kli_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface kli_rsp_if;
	import kli_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== design/keyframe_linear_interpolator.sv =====
// Keyframe linear interpolator top level: key tables, walk, divider, blend.
// Depends on kli_pkg, kli_if (kli_req_if, kli_rsp_if), kli_ram, assert_macros.svh.
//
// Holds up to MAX_KEYS keyframes (unsigned Q16.16 time, signed Q16.16 xyz)
// in two RAMs, expected sorted by time. A write transaction (cmd 0) stores one
// key; slots at or beyond MAX_KEYS are dropped. A query transaction (cmd 1)
// returns one result: key 0 (region 0) when only one key is in use or the time
// is at or before key 0, key n-1 (region 2) when the time lies past every
// segment, else the blend of the first segment holding the time (region 1).
// The query walks the time RAM one segment per cycle, then a shift-subtract
// divider forms the Q0.16 fraction one bit per cycle, and one shared multiplier
// blends x, y, z in turn. The divider and multiplier are skipped when the first
// key is held, or when a key is held after the walk (last key, zero-length
// segment or time on a segment end). The block takes no new transaction until
// the query is done. The result sits in an output register, so the next
// transaction is taken while a result waits. key_count (APB address 0, reset
// 1) is read when a query is accepted; 0 counts as 1 and values above MAX_KEYS
// saturate. Keys must be written before a query can reach them.
module keyframe_linear_interpolator #(
	parameter int MAX_KEYS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	kli_req_if.sink                     req,
	kli_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kli_pkg::ADDR_W-1:0]  paddr,
	input  logic [kli_pkg::DATA_W-1:0]  pwdata,
	output logic [kli_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import kli_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = ((AW > 7) ? AW : 7) + 1;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_T0   = 4'd1;
	localparam logic [3:0] S_WALK = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_RA   = 4'd4;
	localparam logic [3:0] S_RB   = 4'd5;
	localparam logic [3:0] S_LB   = 4'd6;
	localparam logic [3:0] S_DIFF = 4'd7;
	localparam logic [3:0] S_MUL  = 4'd8;
	localparam logic [3:0] S_ACC  = 4'd9;
	localparam logic [3:0] S_HRD  = 4'd10;
	localparam logic [3:0] S_HOLD = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0]  state_q;
	logic [6:0]  key_count_q;
	logic [6:0]  n_q;
	logic [31:0] q_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] slot_q;
	logic [31:0] t_prev_q;
	logic [31:0] span_q;
	logic [31:0] rem_q;
	logic [15:0] quo_q;
	logic [3:0]  bit_q;
	logic [1:0]  comp_q;
	logic [2:0][31:0] a_q;
	logic [2:0][31:0] b_q;
	logic signed [32:0] diff_q;
	logic signed [49:0] prod_q;
	rsp_t        res_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	// ---------------------------------------------------------------- APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[ADDR_W-1:2] == REG_KEY_COUNT);
	assign prdata = (paddr[ADDR_W-1:2] == REG_KEY_COUNT) ? DATA_W'(key_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 7'd1;
		end else if (cfg_wr) begin
			key_count_q <= pwdata[6:0];
		end
	end

	// ---------------------------------------------------------------- intake
	logic req_fire;
	logic key_wr;
	logic [6:0] n_w;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign key_wr    = req_fire && (req.payload.cmd == CMD_WRITE)
		&& (32'(req.payload.key_slot) < MAX_KEYS);

	// effective key count: zero counts as one, saturate at table depth
	always_comb begin
		if (key_count_q == 7'd0) begin
			n_w = 7'd1;
		end else if (32'(key_count_q) > MAX_KEYS) begin
			n_w = 7'(MAX_KEYS);
		end else begin
			n_w = key_count_q;
		end
	end

	// ---------------------------------------------------------------- key RAMs
	logic [AW-1:0] t_raddr;
	logic [AW-1:0] v_raddr;
	logic [31:0]   t_rdata;
	logic [95:0]   v_rdata;

	always_comb begin
		case (state_q)
			S_IDLE:  t_raddr = '0;
			S_T0:    t_raddr = AW'(1);
			S_WALK:  t_raddr = i_q + AW'(2);
			default: t_raddr = i_q;
		endcase
	end

	always_comb begin
		case (state_q)
			S_RB:    v_raddr = slot_q + AW'(1);
			default: v_raddr = slot_q;
		endcase
	end

	kli_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
		.clk   (clk),
		.we    (key_wr),
		.waddr (AW'(req.payload.key_slot)),
		.wdata (req.payload.key_time),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	kli_ram #(.WIDTH(96), .DEPTH(MAX_KEYS)) u_value_ram (
		.clk   (clk),
		.we    (key_wr),
		.waddr (AW'(req.payload.key_slot)),
		.wdata ({req.payload.key_z, req.payload.key_y, req.payload.key_x}),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// ---------------------------------------------------------------- datapath
	logic        in_seg;
	logic [31:0] span_w;
	logic [31:0] d_w;
	logic        more_segs;
	logic [32:0] rem_sh;
	logic        rem_ge;
	logic signed [49:0] rnd_w;
	logic [31:0] blend_w;

	// segment test against the key just read
	assign in_seg = (t_prev_q <= q_q) && (q_q <= t_rdata);
	assign span_w = t_rdata - t_prev_q;
	assign d_w    = q_q - t_prev_q;
	// is there a segment after the current one
	assign more_segs = (CW'(i_q) + CW'(2)) < CW'(n_q);

	// restoring divider step
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = rem_sh >= {1'b0, span_q};

	// round to nearest, floor, then offset from the earlier key
	assign rnd_w   = prod_q + 50'sd32768;
	assign blend_w = a_q[comp_q] + rnd_w[47:16];

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					q_q <= req.payload.query_time;
					n_q <= n_w;
				end
			end
			S_T0: begin
				if (n_q == 7'd1 || q_q <= t_rdata) begin
					slot_q       <= '0;
					res_q.region <= REGION_FIRST;
				end
				t_prev_q <= t_rdata;
				i_q      <= '0;
			end
			S_WALK: begin
				if (in_seg) begin
					res_q.region <= REGION_INTERP;
					span_q       <= span_w;
					rem_q        <= d_w;
					bit_q        <= '0;
					if (span_w == 32'd0) begin
						slot_q <= i_q;
					end else if (d_w == span_w) begin
						slot_q <= i_q + AW'(1);
					end else begin
						slot_q <= i_q;
					end
				end else begin
					t_prev_q <= t_rdata;
					i_q      <= i_q + AW'(1);
					if (!more_segs) begin
						slot_q       <= AW'(n_q - 7'd1);
						res_q.region <= REGION_LAST;
					end
				end
			end
			S_DIV: begin
				rem_q <= rem_ge ? 32'(rem_sh - {1'b0, span_q}) : rem_sh[31:0];
				quo_q <= {quo_q[14:0], rem_ge};
				bit_q <= bit_q + 4'd1;
			end
			S_RB: begin
				a_q <= v_rdata;
			end
			S_LB: begin
				b_q    <= v_rdata;
				comp_q <= '0;
			end
			S_DIFF: begin
				diff_q <= $signed({b_q[comp_q][31], b_q[comp_q]})
					- $signed({a_q[comp_q][31], a_q[comp_q]});
			end
			S_MUL: begin
				prod_q <= 50'(diff_q * $signed({1'b0, quo_q}));
			end
			S_ACC: begin
				case (comp_q)
					2'd0:    res_q.out_x <= blend_w;
					2'd1:    res_q.out_y <= blend_w;
					default: res_q.out_z <= blend_w;
				endcase
				comp_q <= comp_q + 2'd1;
			end
			S_HOLD: begin
				res_q.out_x <= v_rdata[31:0];
				res_q.out_y <= v_rdata[63:32];
				res_q.out_z <= v_rdata[95:64];
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && req.payload.cmd == CMD_QUERY) begin
						state_q <= S_T0;
					end
				end
				S_T0: begin
					if (n_q == 7'd1 || q_q <= t_rdata) begin
						state_q <= S_HRD;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (in_seg) begin
						if (span_w == 32'd0 || d_w == span_w) begin
							state_q <= S_HRD;
						end else begin
							state_q <= S_DIV;
						end
					end else if (!more_segs) begin
						state_q <= S_HRD;
					end
				end
				S_DIV: begin
					if (bit_q == 4'd15) begin
						state_q <= S_RA;
					end
				end
				S_RA:   state_q <= S_RB;
				S_RB:   state_q <= S_LB;
				S_LB:   state_q <= S_DIFF;
				S_DIFF: state_q <= S_MUL;
				S_MUL:  state_q <= S_ACC;
				S_ACC: begin
					if (comp_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_HRD:  state_q <= S_HOLD;
				S_HOLD: state_q <= S_DONE;
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- result register
	logic rsp_load;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// ---------------------------------------------------------------- checks
	`KLI_ASSERT_NEXT(a_query_starts_walk, req_fire && req.payload.cmd == CMD_QUERY, state_q == S_T0, "query did not start the table walk")
	`KLI_ASSERT_NOW(a_walk_in_range, state_q == S_WALK, (CW'(i_q) + CW'(1)) < CW'(n_q), "walk index past last segment")
	`KLI_ASSERT_NOW(a_div_rem_below_span, state_q == S_DIV, rem_q < span_q, "divider remainder not below span")
	`KLI_ASSERT_NOW(a_result_region_valid, $rose(rsp_valid_q), rsp_q.region == REGION_FIRST || rsp_q.region == REGION_INTERP || rsp_q.region == REGION_LAST, "result carries no valid region")

endmodule

// ===== design/kli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keyframe_linear_interpolator: directed and random key/query
// traffic with random idling on both channels, checked against an in-bench predictor.
// Depends on kli_pkg, kli_if (kli_req_if, kli_rsp_if) and the design top level.
module tb_top;
	import kli_pkg::*;

	localparam int MAX_KEYS     = 64;
	localparam int ITEM_TARGET  = 1550;
	localparam int DRAIN_CYCLES = 16;    // margin for a trailing write to retire before a cfg write
	localparam int TAIL_CYCLES  = 128;
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off for back-pressure
	localparam int STALL_LIMIT  = 4000;  // cycles without any transaction before giving up
	localparam int PRINT_LIMIT  = 50;
	localparam logic [ADDR_W-1:0] KEY_COUNT_ADDR = ADDR_W'(REG_KEY_COUNT) << 2;
	// key_count corners in turn: 64, 0 (acts as one), 127, 1, 65, 2, 100; past 64 saturates
	localparam logic [6:0] CORNER_COUNTS [7] = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd65, 7'd2, 7'd100};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// APB side, idle from time zero
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Channel drive registers, so the block sees known values from the first instant
	logic src_valid = 1'b0;
	req_t src_item = '0;
	logic sink_ready = 1'b0;

	kli_req_if req_ch();
	kli_rsp_if rsp_ch();

	assign req_ch.valid   = src_valid;
	assign req_ch.payload = src_item;
	assign rsp_ch.ready   = sink_ready;

	keyframe_linear_interpolator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial forever #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: mirror of the key tables and the key_count register
	// ------------------------------------------------------------------
	logic [31:0]        key_times [MAX_KEYS];
	logic signed [31:0] key_vals  [MAX_KEYS][3];
	logic [6:0]         key_count_cfg = 7'd1;

	req_t keyframe_ops [$];       // transactions waiting for the driver
	rsp_t predicted_samples [$];  // expected results, oldest first

	int issued_count = 0;
	int accepted_count = 0;
	int write_count = 0;
	int query_count = 0;
	int first_count = 0;
	int interp_count = 0;
	int last_count = 0;
	int setting_count = 0;
	int error_count = 0;

	// Idling control, set between phases by the stimulus
	bit steady_src = 1'b0;
	bit steady_sink = 1'b0;
	bit hold_req = 1'b0;

	// Zero counts as one key, anything past the table saturates
	function automatic int active_keys(input logic [6:0] cfg);
		if (cfg == 0)
			return 1;
		if (cfg > MAX_KEYS)
			return MAX_KEYS;
		return int'(cfg);
	endfunction

	function automatic rsp_t key_sample(input int idx, input logic [1:0] region);
		rsp_t res;
		res.out_x  = key_vals[idx][0];
		res.out_y  = key_vals[idx][1];
		res.out_z  = key_vals[idx][2];
		res.region = region;
		return res;
	endfunction

	// Value of the track at time qt: hold first, blend in the first segment that
	// holds qt (Q0.16 fraction, rounded blend), else hold last.
	function automatic rsp_t sample_track(input logic [31:0] qt);
		rsp_t res;
		int n;
		logic [31:0] t_lo, t_hi, seg_len, offset;
		logic [47:0] frac;
		longint a, b, v;
		logic [31:0] mix [3];
		n = active_keys(key_count_cfg);
		if (n == 1 || qt <= key_times[0])
			return key_sample(0, REGION_FIRST);
		for (int i = 0; i + 1 < n; i++) begin
			t_lo = key_times[i];
			t_hi = key_times[i + 1];
			if (t_lo <= qt && qt <= t_hi) begin
				seg_len = t_hi - t_lo;
				offset  = qt - t_lo;
				// zero-length segment: fraction zero, earlier key
				if (seg_len == 0)
					return key_sample(i, REGION_INTERP);
				// exactly on the segment end: fraction one, later key
				if (offset == seg_len)
					return key_sample(i + 1, REGION_INTERP);
				frac = {offset, 16'h0000} / {16'h0000, seg_len};
				for (int c = 0; c < 3; c++) begin
					a = key_vals[i][c];
					b = key_vals[i + 1][c];
					v = a + (((b - a) * longint'(frac) + 64'sd32768) >>> 16);
					mix[c] = v[31:0];
				end
				res.out_x  = mix[0];
				res.out_y  = mix[1];
				res.out_z  = mix[2];
				res.region = REGION_INTERP;
				return res;
			end
		end
		return key_sample(n - 1, REGION_LAST);
	endfunction

	task automatic flag_error(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic int draw_pause(input bit steady);
		return steady ? 0 : $urandom_range(0, 17);
	endfunction

	// Mostly random words, with the signed and unsigned extremes mixed in
	function automatic logic [31:0] draw_word();
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_key(input logic [5:0] slot, input logic [31:0] kt,
			input logic [31:0] kx, input logic [31:0] ky, input logic [31:0] kz);
		req_t item;
		item.cmd        = CMD_WRITE;
		item.key_slot   = slot;
		item.key_time   = kt;
		item.key_x      = kx;
		item.key_y      = ky;
		item.key_z      = kz;
		item.query_time = $urandom;     // don't-care on a write
		keyframe_ops = {keyframe_ops, item};
		issued_count++;
	endtask

	task automatic push_query(input logic [31:0] qt);
		req_t item;
		item.cmd        = CMD_QUERY;
		item.key_slot   = 6'($urandom);  // key fields are don't-care on a query
		item.key_time   = $urandom;
		item.key_x      = $urandom;
		item.key_y      = $urandom;
		item.key_z      = $urandom;
		item.query_time = qt;
		keyframe_ops = {keyframe_ops, item};
		issued_count++;
	endtask

	// Block is idle once every transaction is taken and every result is back;
	// a trailing write may still be retiring, hence the short drain.
	task automatic wait_idle();
		while (accepted_count != issued_count || predicted_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write of key_count, then a read-back of the same register
	task automatic set_key_count(input logic [6:0] cfg);
		wait_idle();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= KEY_COUNT_ADDR;
		pwdata  <= DATA_W'(cfg);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		key_count_cfg = cfg;    // register takes the value at this edge
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[6:0] !== cfg)
			flag_error($sformatf("key_count read back %h, wrote %h", prdata[6:0], cfg));
		psel    <= 1'b0;
		penable <= 1'b0;
		setting_count++;
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued transactions, random gap after each one.
	// Predictions are made at acceptance so they see the table as it was then.
	// ------------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : source_side
		rsp_t want;
		if (!arst_n) begin
			src_valid <= 1'b0;
			gap_left  <= 0;
		end else begin
			if (src_valid && req_ch.ready) begin
				if (src_item.cmd == CMD_WRITE) begin
					key_times[src_item.key_slot]   = src_item.key_time;
					key_vals[src_item.key_slot][0] = src_item.key_x;
					key_vals[src_item.key_slot][1] = src_item.key_y;
					key_vals[src_item.key_slot][2] = src_item.key_z;
					write_count++;
				end else begin
					want = sample_track(src_item.query_time);
					predicted_samples = {predicted_samples, want};
					query_count++;
					case (want.region)
						REGION_FIRST:  first_count++;
						REGION_INTERP: interp_count++;
						default:       last_count++;
					endcase
				end
				accepted_count++;
			end
			if (!src_valid || req_ch.ready) begin
				if (gap_left != 0) begin
					gap_left  <= gap_left - 1;
					src_valid <= 1'b0;
				end else if (keyframe_ops.size() != 0) begin
					src_item  <= keyframe_ops.pop_front();
					src_valid <= 1'b1;
					gap_left  <= draw_pause(steady_src);
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long hold-off: a toggle of hold_req starts a stretch of HOLD_CYCLES in
	// which the receiver refuses results while the driver keeps offering.
	// ------------------------------------------------------------------
	bit hold_seen = 1'b0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: takes results, compares each field with the oldest prediction,
	// then stalls for a random pause, none when steady_sink is set.
	// ------------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin : sink_side
		rsp_t want;
		int pause;
		if (!arst_n) begin
			sink_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			pause = 0;
			if (rsp_ch.valid && sink_ready) begin
				if (predicted_samples.size() == 0) begin
					flag_error("result transaction with no query outstanding");
				end else begin
					want = predicted_samples.pop_front();
					if (rsp_ch.payload.out_x !== want.out_x)
						flag_error($sformatf("out_x got %h want %h", rsp_ch.payload.out_x,
							want.out_x));
					if (rsp_ch.payload.out_y !== want.out_y)
						flag_error($sformatf("out_y got %h want %h", rsp_ch.payload.out_y,
							want.out_y));
					if (rsp_ch.payload.out_z !== want.out_z)
						flag_error($sformatf("out_z got %h want %h", rsp_ch.payload.out_z,
							want.out_z));
					if (rsp_ch.payload.region !== want.region)
						flag_error($sformatf("region got %0d want %0d", rsp_ch.payload.region,
							want.region));
				end
				pause = draw_pause(steady_sink);
			end
			if (pause != 0) begin
				stall_left <= pause - 1;
				sink_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				sink_ready <= 1'b0;
			end else begin
				sink_ready <= (hold_left == 0);
			end
		end
	end

	// Watchdog: any accepted transaction on either channel resets the count
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (src_valid && req_ch.ready) || (rsp_ch.valid && sink_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				STALL_LIMIT, predicted_samples.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int phase, n, nq, k, j, slot, mode;
		logic [6:0] cfg;
		logic [31:0] kt, qt, lo, hi;
		longint unsigned acc;
		logic [31:0] gen_times [$];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single key ignores the time, zero key_count acts as one
		push_key(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		push_query(32'hFFFF_FFFF);
		set_key_count(7'd0);
		push_query(32'h0002_0000);
		// full-scale swing on the first segment, duplicate time on the second,
		// last key at the top of the time range, top slot written but unused
		push_key(6'd1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_key(6'd2, 32'h0003_0000, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001);
		push_key(6'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		push_key(6'd63, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		set_key_count(7'd4);
		push_query(32'h0000_0000);    // before the first key
		push_query(32'h0001_0000);    // on the first key
		push_query(32'h0001_0001);    // just inside the first segment
		push_query(32'h0002_0000);    // midpoint of the full-scale swing
		push_query(32'h0002_FFFF);
		push_query(32'h0003_0000);    // on a segment end: later key exactly
		push_query(32'h8000_0000);
		push_query(32'hFFFF_FFFF);    // on the last key
		set_key_count(7'd3);
		push_query(32'h0003_0001);    // past the last key in use
		push_query(32'hFFFF_FFFF);

		// Random phases: new key_count, a fresh table, then queries with some noise writes
		for (phase = 0; issued_count < ITEM_TARGET; phase++) begin
			if (phase % 6 == 0)
				cfg = CORNER_COUNTS[(phase / 6) % 7];
			else if ($urandom_range(0, 3) == 0)
				cfg = 7'($urandom_range(10, 63));
			else
				cfg = 7'($urandom_range(2, 9));
			set_key_count(cfg);
			n = active_keys(cfg);
			steady_src  = ($urandom_range(0, 3) == 0);
			steady_sink = ($urandom_range(0, 3) == 0);

			// Table times: wide random (sorted), dense ramp, or tight steps with repeats
			mode = $urandom_range(0, 2);
			gen_times.delete();
			for (k = 0; k < n; k++) begin
				if (mode == 0 || k == 0)
					acc = (mode == 1) ? 64'($urandom_range(0, 32'h0004_0000)) : 64'($urandom);
				else if (mode == 1)
					acc = 64'(gen_times[k - 1]) + 64'($urandom_range(0, 32'h0002_0000));
				else
					acc = 64'(gen_times[k - 1]) +
						(($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 255)));
				kt = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
				gen_times = {gen_times, kt};
			end
			if (mode == 0)
				gen_times.sort();
			// now and then the table goes out of order
			if (n > 1 && $urandom_range(0, 7) == 0) begin
				repeat (2) begin
					j = $urandom_range(0, n - 1);
					k = $urandom_range(0, n - 1);
					kt = gen_times[j];
					gen_times[j] = gen_times[k];
					gen_times[k] = kt;
				end
			end
			for (k = 0; k < n; k++)
				push_key(6'(k), gen_times[k], draw_word(), draw_word(), draw_word());

			nq = $urandom_range(8, 30);
			for (j = 0; j < nq; j++) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise write anywhere in the table
					slot = $urandom_range(0, MAX_KEYS - 1);
					kt = draw_word();
					push_key(6'(slot), kt, draw_word(), draw_word(), draw_word());
					if (slot < n)
						gen_times[slot] = kt;
				end else begin
					k  = (n > 1) ? $urandom_range(0, n - 2) : 0;
					lo = gen_times[k];
					hi = gen_times[(n > 1) ? k + 1 : 0];
					case ($urandom_range(0, 7))
						0, 1, 2: qt = (lo <= hi) ?
							lo + 32'($urandom % (64'(hi) - 64'(lo) + 64'd1)) : $urandom;
						3: qt = gen_times[$urandom_range(0, n - 1)];
						4: qt = $urandom_range(0, gen_times[0]);
						5: qt = (gen_times[n - 1] == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF :
							$urandom_range(gen_times[n - 1] + 32'd1, 32'hFFFF_FFFF);
						6: qt = lo + 32'($urandom_range(0, 2)) - 32'd1;
						default: qt = $urandom;
					endcase
					push_query(qt);
				end
			end

			// back-pressure: receiver refuses results while the queue keeps feeding
			if (phase == 3 || $urandom_range(0, 19) == 0)
				hold_req = !hold_req;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (predicted_samples.size() != 0)
			flag_error($sformatf("%0d results never arrived", predicted_samples.size()));

		$display("Covered %0d key writes and %0d queries over %0d key_count settings",
			write_count, query_count, setting_count);
		$display("Query outcomes: %0d first held, %0d interpolated, %0d last held; %0d errors",
			first_count, interp_count, last_count, error_count);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/kli_pkg.sv
design/kli_if.sv
design/kli_ram.sv
design/keyframe_linear_interpolator.sv
tb/tb_top.sv
